// ===== sv/bc1_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1_pkg
// Shared types, constants and palette arithmetic for the BC1 block decoder.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int ROWS_PER_BLOCK = 4;
  localparam int PIXELS_PER_ROW = 4;
  localparam int PALETTE_SIZE   = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0]  ROW_LAST     = 2'd3;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [31:0] PIX_CLEAR    = 32'h0000_0000;

  typedef logic [31:0] pixel_t;
  typedef pixel_t [PALETTE_SIZE-1:0] palette_t;

  // one decoded block waiting for row output
  typedef struct packed {
    palette_t    pal;
    logic [31:0] indices;
  } q_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // 5-bit endpoint channel to 8 bits
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd527 + 15'd23;
    return p[13:6];
  endfunction

  // 6-bit endpoint channel to 8 bits
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] p;
    p = 14'(v) * 14'd259 + 14'd33;
    return p[13:6];
  endfunction

  // one-third interpolant, s = 2a+b of 5-bit channels
  function automatic logic [7:0] third5(input logic [6:0] s);
    logic [14:0] p;
    p = 15'(s) * 15'd351 + 15'd61;
    return p[14:7];
  endfunction

  // one-third interpolant, s = 2a+b of 6-bit channels
  function automatic logic [7:0] third6(input logic [7:0] s);
    logic [18:0] p;
    p = 19'(s) * 19'd2763 + 19'd1039;
    return p[18:11];
  endfunction

  // midpoint, s = a+b of 5-bit channels
  function automatic logic [7:0] mid5(input logic [5:0] s);
    logic [15:0] p;
    p = 16'(s) * 16'd1053 + 16'd125;
    return p[15:8];
  endfunction

  // midpoint, s = a+b of 6-bit channels
  function automatic logic [7:0] mid6(input logic [6:0] s);
    logic [18:0] p;
    p = 19'(s) * 19'd4145 + 19'd1019;
    return p[18:11];
  endfunction

  function automatic pixel_t pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return {ALPHA_OPAQUE, b, g, r};
  endfunction

  // full four-entry palette from two RGB565 endpoints
  function automatic palette_t make_palette(input logic [15:0] c0,
                                            input logic [15:0] c1);
    palette_t   pal;
    logic [4:0] r0, b0, r1, b1;
    logic [5:0] g0, g1;
    r0 = c0[15:11];
    g0 = c0[10:5];
    b0 = c0[4:0];
    r1 = c1[15:11];
    g1 = c1[10:5];
    b1 = c1[4:0];
    pal[0] = pack_rgb(expand5(r0), expand6(g0), expand5(b0));
    pal[1] = pack_rgb(expand5(r1), expand6(g1), expand5(b1));
    if (c0 > c1) begin
      pal[2] = pack_rgb(third5({1'b0, r0, 1'b0} + 7'(r1)),
                        third6({1'b0, g0, 1'b0} + 8'(g1)),
                        third5({1'b0, b0, 1'b0} + 7'(b1)));
      pal[3] = pack_rgb(third5(7'(r0) + {1'b0, r1, 1'b0}),
                        third6(8'(g0) + {1'b0, g1, 1'b0}),
                        third5(7'(b0) + {1'b0, b1, 1'b0}));
    end else begin
      pal[2] = pack_rgb(mid5(6'(r0) + 6'(r1)),
                        mid6(7'(g0) + 7'(g1)),
                        mid5(6'(b0) + 6'(b1)));
      pal[3] = PIX_CLEAR;
    end
    return pal;
  endfunction

endpackage

// ===== sv/bc1_if.sv =====
// ----------------------------------------------------------------------------
// bc1 channel interfaces
// Valid/ready channels for compressed blocks in and decoded rows out.
// ----------------------------------------------------------------------------
interface bc1_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] color0;
  logic [15:0] color1;
  logic [31:0] indices;

  modport source (output valid, output color0, output color1, output indices,
                  input ready);
  modport sink   (input valid, input color0, input color1, input indices,
                  output ready);
endinterface

interface bc1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [1:0]  row;
  logic        last_row;

  modport source (output valid, output pixel_0, output pixel_1, output pixel_2,
                  output pixel_3, output row, output last_row, input ready);
  modport sink   (input valid, input pixel_0, input pixel_1, input pixel_2,
                  input pixel_3, input row, input last_row, output ready);
endinterface

// ===== sv/bc1_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// bc1_block_decoder_top
// BC1 (DXT1) block decoder: one 64-bit block in, four rows of RGBA8 out.
// ----------------------------------------------------------------------------
// Usage:
//   blk  - valid/ready channel carrying color0, color1 (RGB565) and the
//          sixteen 2-bit indices of one block.
//   pix  - valid/ready channel carrying one row per request: four RGBA8
//          pixels (R in the low byte), the row number and last_row.
// Path: when nothing stalls, a block passes the input register, the queue
//   and the output register in that order before its first row leaves.
// Throughput: one row per cycle while pix.ready is high, four rows per
//   block; the row emitter and its output register set this rate. The input
//   side keeps taking blocks while the queue (QueueDepth entries) has room.
// Reset: rst clears the input hold, the queue and the row counter; no
//   block is in flight afterwards.
// Stall: when pix.ready is low the current row stays put, the queue fills,
//   and blk.ready drops once the queue and the input register are full.
// ----------------------------------------------------------------------------
module bc1_block_decoder_top import bc1_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  bc1_in_if.sink    blk,
  bc1_out_if.source pix
);

  q_stat_t  qstat;
  q_entry_t push_data;
  q_entry_t head;
  logic     push;
  logic     pop;

  // palette front end
  bc1_front u_front (
    .clk       (clk),
    .rst       (rst),
    .blk       (blk),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  bc1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // row emitter
  bc1_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .pix   (pix)
  );

endmodule

// ===== sv/bc1_front.sv =====
// ----------------------------------------------------------------------------
// bc1_front
// Accepts compressed blocks, builds the palette and pushes it to the queue.
// ----------------------------------------------------------------------------
module bc1_front import bc1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bc1_in_if.sink     blk,
  input  q_stat_t    qstat,
  output logic       push,
  output q_entry_t   push_data
);

  logic        valid;
  logic [15:0] color0;
  logic [15:0] color1;
  logic [31:0] indices;

  // hold one block until the queue takes it
  assign push      = valid && !qstat.full;
  assign blk.ready = !valid || !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (blk.valid && blk.ready) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  // block payload
  always_ff @(posedge clk) begin
    if (blk.valid && blk.ready) begin
      color0  <= blk.color0;
      color1  <= blk.color1;
      indices <= blk.indices;
    end
  end

  // palette from the held endpoints
  always_comb begin
    push_data.pal     = make_palette(color0, color1);
    push_data.indices = indices;
  end

endmodule

// ===== sv/bc1_queue.sv =====
// ----------------------------------------------------------------------------
// bc1_queue
// Short queue of decoded palettes between the front and the row emitter.
// ----------------------------------------------------------------------------
module bc1_queue import bc1_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  qstat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  q_entry_t        entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign qstat.full  = (count == CntFull);
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/bc1_back.sv =====
// ----------------------------------------------------------------------------
// bc1_back
// Emits the four rows of the queue head, one row per cycle while pix.ready
// is high, through an output register.
// ----------------------------------------------------------------------------
module bc1_back import bc1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t head,
  input  q_stat_t  qstat,
  output logic     pop,
  bc1_out_if.source pix
);

  logic [1:0] row_cnt;
  logic       load;
  logic [7:0] row_idx;
  pixel_t     row_pix [PIXELS_PER_ROW];

  // next row goes out when the output register is free
  assign load = (!pix.valid || pix.ready) && !qstat.empty;
  assign pop  = load && (row_cnt == ROW_LAST);

  // palette lookup for the current row
  always_comb begin
    row_idx = head.indices[8*row_cnt +: 8];
    for (int p = 0; p < PIXELS_PER_ROW; p++) begin
      row_pix[p] = head.pal[row_idx[2*p +: 2]];
    end
  end

  // row counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      pix.valid <= 1'b0;
    end else begin
      if (load) begin
        row_cnt   <= row_cnt + 1'b1;
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pix.pixel_0  <= row_pix[0];
      pix.pixel_1  <= row_pix[1];
      pix.pixel_2  <= row_pix[2];
      pix.pixel_3  <= row_pix[3];
      pix.row      <= row_cnt;
      pix.last_row <= (row_cnt == ROW_LAST);
    end
  end

endmodule
